// ----- hw/rtl/garm_pkg.sv -----
// Guest address region map: shared types and codes.
// Command, status and state encodings, table entry layouts and the result record.
// No dependencies.
package garm_pkg;

    typedef enum logic [2:0] {
        CMD_ADD_AREA  = 3'd0,
        CMD_ADD_DEV   = 3'd1,
        CMD_TRANSLATE = 3'd2,
        CMD_FIND_DEV  = 3'd3,
        CMD_READ_DEV  = 3'd4
    } cmd_code_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_RANGE = 3'd1,
        ST_FULL      = 3'd2,
        ST_OVL_AREA  = 3'd3,
        ST_OVL_DEV   = 3'd4,
        ST_NULL_HOST = 3'd5,
        ST_NOT_FOUND = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [63:0] host;
        logic [63:0] size;
        logic [63:0] start;
    } area_ent_t;

    typedef struct packed {
        logic [31:0] tag;
        logic [63:0] size;
        logic [63:0] start;
    } win_ent_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [63:0] address;
        logic [63:0] span;
        logic [63:0] host_base;
        logic [31:0] dev_tag;
        logic [3:0]  entry_index;
    } cmd_t;

    typedef struct packed {
        status_t     status;
        logic [63:0] result_address;
        logic [31:0] found_tag;
        logic [63:0] entry_base;
        logic [63:0] entry_span;
        logic [4:0]  areas_used;
        logic [4:0]  devices_used;
    } result_t;

endpackage

// ----- hw/rtl/guest_address_region_map.sv -----
// Guest address region map: top level.
// Output register on the result stream; instantiates garm_ctrl and two garm_mem tables.
// Depends on garm_pkg, garm_mem, garm_ctrl.
//
// Usage:
//   s_axis carries one command per transfer (add area, add device window,
//   translate, find device window, read device window entry). m_axis returns
//   exactly one result per command, in order.
//   One command is worked on at a time. After acceptance the sequencer checks
//   the range, reads the memories once per entry scanned (L reads), compares
//   the last read and hands the result to the output register. L is the
//   larger of the two table counts for an add, the area count for translate,
//   the window count for find, 1 for read entry, and 0 for a command refused
//   by the range or full check or an unused code. The next command is taken
//   only after the result of the previous one has gone to the output register.
//   With L of 0 there is no read or compare.
//   The scan rate is set by the single read port of each table memory.
//   Reset empties both tables (counts to zero); no memory clearing pass.
//   If m_axis stalls, one result waits in the output register while the next
//   command is worked on; that command then waits for the register to drain.
module guest_address_region_map
    import garm_pkg::*;
#(
    parameter int AREA_ENTRIES   = 16,
    parameter int WINDOW_ENTRIES = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // cmd[2:0], address[66:3], span[130:67], host_base[194:131],
    // dev_tag[226:195], entry_index[230:227], zero[231]
    input  logic [231:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[2:0], result_address[66:3], found_tag[98:67], entry_base[162:99],
    // entry_span[226:163], areas_used[231:227], devices_used[236:232], zero[239:237]
    output logic [239:0] m_axis_tdata
);

    localparam int AAW = (AREA_ENTRIES > 1) ? $clog2(AREA_ENTRIES) : 1;
    localparam int WAW = (WINDOW_ENTRIES > 1) ? $clog2(WINDOW_ENTRIES) : 1;

    cmd_t           in_cmd;
    result_t        res;
    logic           res_valid, res_ready;
    logic           area_wr_en, area_rd_en, win_wr_en, win_rd_en;
    logic [AAW-1:0] area_wr_addr, area_rd_addr;
    logic [WAW-1:0] win_wr_addr, win_rd_addr;
    area_ent_t      area_wr_data, area_rd_data;
    win_ent_t       win_wr_data, win_rd_data;
    logic           out_v_reg, out_v_next;
    logic [239:0]   out_data_reg, out_data_next;

    assign in_cmd.cmd         = s_axis_tdata[2:0];
    assign in_cmd.address     = s_axis_tdata[66:3];
    assign in_cmd.span        = s_axis_tdata[130:67];
    assign in_cmd.host_base   = s_axis_tdata[194:131];
    assign in_cmd.dev_tag     = s_axis_tdata[226:195];
    assign in_cmd.entry_index = s_axis_tdata[230:227];

    garm_mem #(
        .DEPTH (AREA_ENTRIES),
        .WIDTH ($bits(area_ent_t)),
        .AW    (AAW)
    ) u_area_mem (
        .clk     (clk),
        .wr_en   (area_wr_en),
        .wr_addr (area_wr_addr),
        .wr_data (area_wr_data),
        .rd_en   (area_rd_en),
        .rd_addr (area_rd_addr),
        .rd_data (area_rd_data)
    );

    garm_mem #(
        .DEPTH (WINDOW_ENTRIES),
        .WIDTH ($bits(win_ent_t)),
        .AW    (WAW)
    ) u_win_mem (
        .clk     (clk),
        .wr_en   (win_wr_en),
        .wr_addr (win_wr_addr),
        .wr_data (win_wr_data),
        .rd_en   (win_rd_en),
        .rd_addr (win_rd_addr),
        .rd_data (win_rd_data)
    );

    garm_ctrl #(
        .AREA_ENTRIES   (AREA_ENTRIES),
        .WINDOW_ENTRIES (WINDOW_ENTRIES),
        .AAW            (AAW),
        .WAW            (WAW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_cmd       (in_cmd),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .area_wr_en   (area_wr_en),
        .area_wr_addr (area_wr_addr),
        .area_wr_data (area_wr_data),
        .area_rd_en   (area_rd_en),
        .area_rd_addr (area_rd_addr),
        .area_rd_data (area_rd_data),
        .win_wr_en    (win_wr_en),
        .win_wr_addr  (win_wr_addr),
        .win_wr_data  (win_wr_data),
        .win_rd_en    (win_rd_en),
        .win_rd_addr  (win_rd_addr),
        .win_rd_data  (win_rd_data)
    );

    // output register: loads when empty or draining this cycle
    assign res_ready = !out_v_reg || m_axis_tready;

    always_comb
    begin
        out_v_next    = out_v_reg;
        out_data_next = out_data_reg;
        if (m_axis_tready)
        begin
            out_v_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            out_v_next    = 1'b1;
            out_data_next = {3'b000, res.devices_used, res.areas_used, res.entry_span,
                             res.entry_base, res.found_tag, res.result_address, res.status};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ----- hw/rtl/garm_mem.sv -----
// Guest address region map: single-port-write, single-port-read table memory.
// Synchronous write, registered read.
// No dependencies.
module garm_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 192,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/garm_ctrl.sv -----
// Guest address region map: command sequencer.
// Scans both region memories for overlap or containment, or reads a window entry; one result per command.
// Depends on garm_pkg; drives two garm_mem instances.
module garm_ctrl
    import garm_pkg::*;
#(
    parameter int AREA_ENTRIES   = 16,
    parameter int WINDOW_ENTRIES = 16,
    parameter int AAW            = (AREA_ENTRIES > 1) ? $clog2(AREA_ENTRIES) : 1,
    parameter int WAW            = (WINDOW_ENTRIES > 1) ? $clog2(WINDOW_ENTRIES) : 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  cmd_t           in_cmd,
    output logic           res_valid,
    input  logic           res_ready,
    output result_t        res,
    output logic           area_wr_en,
    output logic [AAW-1:0] area_wr_addr,
    output area_ent_t      area_wr_data,
    output logic           area_rd_en,
    output logic [AAW-1:0] area_rd_addr,
    input  area_ent_t      area_rd_data,
    output logic           win_wr_en,
    output logic [WAW-1:0] win_wr_addr,
    output win_ent_t       win_wr_data,
    output logic           win_rd_en,
    output logic [WAW-1:0] win_rd_addr,
    input  win_ent_t       win_rd_data
);

    localparam int ACW  = $clog2(AREA_ENTRIES + 1);
    localparam int WCW  = $clog2(WINDOW_ENTRIES + 1);
    localparam int MAXN = (AREA_ENTRIES > WINDOW_ENTRIES) ? AREA_ENTRIES : WINDOW_ENTRIES;
    localparam int CW   = $clog2(MAXN + 1);
    localparam int IXW  = (WCW > 4) ? WCW : 4;
    localparam int XW   = (WAW > 4) ? WAW : 4;
    localparam int AXW  = (ACW > 5) ? ACW : 5;
    localparam int DXW  = (WCW > 5) ? WCW : 5;

    state_t         state_reg, state_next;
    cmd_t           cmd_reg, cmd_next;
    logic [63:0]    end_reg, end_next;
    logic [CW-1:0]  k_reg, k_next;
    logic [CW-1:0]  limit_reg, limit_next;
    logic           rd_v_reg, rd_v_next;
    logic [CW-1:0]  rd_k_reg, rd_k_next;
    logic           flag_a_reg, flag_a_next;
    logic           flag_w_reg, flag_w_next;
    logic           hit_reg, hit_next;
    logic           skip_reg, skip_next;
    status_t        pre_status_reg, pre_status_next;
    logic [63:0]    cap_start_reg, cap_start_next;
    logic [63:0]    cap_size_reg, cap_size_next;
    logic [63:0]    cap_host_reg, cap_host_next;
    logic [31:0]    cap_tag_reg, cap_tag_next;
    logic [ACW-1:0] area_total_reg, area_total_next;
    logic [WCW-1:0] window_total_reg, window_total_next;

    logic           rng_ok, area_full, win_full, idx_ok, last_issue;
    logic [CW-1:0]  a_cnt, w_cnt;
    logic           chk_skip;
    status_t        chk_status;
    logic [CW-1:0]  chk_limit;
    logic [63:0]    a_end, w_end;
    logic           a_valid, w_valid, a_ovl, w_ovl, a_hold, w_hold;
    status_t        fin_status;
    logic           fin_ok, area_inc, win_inc, handover;
    logic [XW-1:0]  idx_ext;
    logic [AXW-1:0] areas_ext;
    logic [DXW-1:0] devs_ext;

    // checks on the held command
    assign rng_ok     = (cmd_reg.span != 64'd0) && (cmd_reg.address <= ~cmd_reg.span);
    assign area_full  = area_total_reg == ACW'(AREA_ENTRIES);
    assign win_full   = window_total_reg == WCW'(WINDOW_ENTRIES);
    assign idx_ok     = IXW'(cmd_reg.entry_index) < IXW'(window_total_reg);
    assign a_cnt      = CW'(area_total_reg);
    assign w_cnt      = CW'(window_total_reg);
    assign last_issue = CW'(k_reg + 1'b1) == limit_reg;
    assign idx_ext    = XW'(cmd_reg.entry_index);

    always_comb
    begin
        chk_skip   = 1'b0;
        chk_status = ST_NOT_FOUND;
        chk_limit  = '0;
        case (cmd_reg.cmd)
            CMD_ADD_AREA, CMD_ADD_DEV:
            begin
                chk_limit = (a_cnt > w_cnt) ? a_cnt : w_cnt;
                if (!rng_ok)
                begin
                    chk_skip   = 1'b1;
                    chk_status = ST_BAD_RANGE;
                end
                else if ((cmd_reg.cmd == CMD_ADD_AREA) ? area_full : win_full)
                begin
                    chk_skip   = 1'b1;
                    chk_status = ST_FULL;
                end
            end
            CMD_TRANSLATE:
            begin
                chk_limit = a_cnt;
                if (!rng_ok)
                begin
                    chk_skip   = 1'b1;
                    chk_status = ST_BAD_RANGE;
                end
            end
            CMD_FIND_DEV:
            begin
                chk_limit = w_cnt;
                if (!rng_ok)
                begin
                    chk_skip   = 1'b1;
                    chk_status = ST_BAD_RANGE;
                end
            end
            CMD_READ_DEV:
            begin
                chk_limit = CW'(1);
            end
            default:
            begin
                chk_skip = 1'b1;
            end
        endcase
    end

    // compare stage on the registered memory data
    assign a_end   = area_rd_data.start + area_rd_data.size;
    assign w_end   = win_rd_data.start + win_rd_data.size;
    assign a_valid = rd_v_reg && (rd_k_reg < a_cnt);
    assign w_valid = rd_v_reg && (rd_k_reg < w_cnt);
    assign a_ovl   = a_valid && (cmd_reg.address < a_end) && (area_rd_data.start < end_reg);
    assign w_ovl   = w_valid && (cmd_reg.address < w_end) && (win_rd_data.start < end_reg);
    assign a_hold  = a_valid && (area_rd_data.start <= cmd_reg.address) && (end_reg <= a_end);
    assign w_hold  = w_valid && (win_rd_data.start <= cmd_reg.address) && (end_reg <= w_end);

    always_comb
    begin
        fin_status = ST_NOT_FOUND;
        if (skip_reg)
        begin
            fin_status = pre_status_reg;
        end
        else
        begin
            case (cmd_reg.cmd)
                CMD_ADD_AREA:
                begin
                    if (flag_a_reg)
                        fin_status = ST_OVL_AREA;
                    else if (flag_w_reg)
                        fin_status = ST_OVL_DEV;
                    else if (cmd_reg.host_base == 64'd0)
                        fin_status = ST_NULL_HOST;
                    else
                        fin_status = ST_OK;
                end
                CMD_ADD_DEV:
                begin
                    if (flag_a_reg)
                        fin_status = ST_OVL_AREA;
                    else if (flag_w_reg)
                        fin_status = ST_OVL_DEV;
                    else
                        fin_status = ST_OK;
                end
                CMD_TRANSLATE, CMD_FIND_DEV, CMD_READ_DEV:
                begin
                    fin_status = hit_reg ? ST_OK : ST_NOT_FOUND;
                end
                default:
                begin
                    fin_status = ST_NOT_FOUND;
                end
            endcase
        end
    end

    assign fin_ok   = fin_status == ST_OK;
    assign area_inc = fin_ok && (cmd_reg.cmd == CMD_ADD_AREA);
    assign win_inc  = fin_ok && (cmd_reg.cmd == CMD_ADD_DEV);
    assign handover = (state_reg == S_FINISH) && res_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (chk_skip || (chk_limit == '0))
                    state_next = S_FINISH;
                else
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (last_issue)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (res_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready     = state_reg == S_IDLE;
        res_valid    = state_reg == S_FINISH;
        area_rd_en   = state_reg == S_SCAN;
        win_rd_en    = state_reg == S_SCAN;
        area_rd_addr = k_reg[AAW-1:0];
        win_rd_addr  = (cmd_reg.cmd == CMD_READ_DEV) ? idx_ext[WAW-1:0] : k_reg[WAW-1:0];
        area_wr_en   = handover && area_inc;
        win_wr_en    = handover && win_inc;
        area_wr_addr = area_total_reg[AAW-1:0];
        win_wr_addr  = window_total_reg[WAW-1:0];
        area_wr_data = '{host: cmd_reg.host_base, size: cmd_reg.span, start: cmd_reg.address};
        win_wr_data  = '{tag: cmd_reg.dev_tag, size: cmd_reg.span, start: cmd_reg.address};

        areas_ext = AXW'(area_total_reg + ACW'(area_inc));
        devs_ext  = DXW'(window_total_reg + WCW'(win_inc));

        res.status         = fin_status;
        res.result_address = 64'd0;
        res.found_tag      = 32'd0;
        res.entry_base     = 64'd0;
        res.entry_span     = 64'd0;
        res.areas_used     = areas_ext[4:0];
        res.devices_used   = devs_ext[4:0];
        if (fin_ok)
        begin
            case (cmd_reg.cmd)
                CMD_ADD_AREA:
                    res.result_address = cmd_reg.host_base;
                CMD_TRANSLATE:
                    res.result_address = cap_host_reg + (cmd_reg.address - cap_start_reg);
                CMD_FIND_DEV:
                begin
                    res.result_address = cmd_reg.address - cap_start_reg;
                    res.found_tag      = cap_tag_reg;
                    res.entry_base     = cap_start_reg;
                    res.entry_span     = cap_size_reg;
                end
                CMD_READ_DEV:
                begin
                    res.found_tag  = cap_tag_reg;
                    res.entry_base = cap_start_reg;
                    res.entry_span = cap_size_reg;
                end
                default:
                    res.result_address = 64'd0;
            endcase
        end
    end

    // datapath
    always_comb
    begin
        cmd_next          = cmd_reg;
        end_next          = end_reg;
        k_next            = k_reg;
        limit_next        = limit_reg;
        rd_v_next         = state_reg == S_SCAN;
        rd_k_next         = k_reg;
        flag_a_next       = flag_a_reg;
        flag_w_next       = flag_w_reg;
        hit_next          = hit_reg;
        skip_next         = skip_reg;
        pre_status_next   = pre_status_reg;
        cap_start_next    = cap_start_reg;
        cap_size_next     = cap_size_reg;
        cap_host_next     = cap_host_reg;
        cap_tag_next      = cap_tag_reg;
        area_total_next   = area_total_reg;
        window_total_next = window_total_reg;

        if ((state_reg == S_IDLE) && in_valid)
        begin
            cmd_next    = in_cmd;
            k_next      = '0;
            flag_a_next = 1'b0;
            flag_w_next = 1'b0;
            hit_next    = 1'b0;
        end

        if (state_reg == S_CHECK)
        begin
            end_next        = cmd_reg.address + cmd_reg.span;
            skip_next       = chk_skip;
            pre_status_next = chk_status;
            limit_next      = chk_limit;
        end

        if (state_reg == S_SCAN)
        begin
            k_next = CW'(k_reg + 1'b1);
        end

        if (rd_v_reg)
        begin
            case (cmd_reg.cmd)
                CMD_ADD_AREA, CMD_ADD_DEV:
                begin
                    flag_a_next = flag_a_reg || a_ovl;
                    flag_w_next = flag_w_reg || w_ovl;
                end
                CMD_TRANSLATE:
                begin
                    if (!hit_reg && a_hold)
                    begin
                        hit_next       = 1'b1;
                        cap_start_next = area_rd_data.start;
                        cap_host_next  = area_rd_data.host;
                    end
                end
                CMD_FIND_DEV:
                begin
                    if (!hit_reg && w_hold)
                    begin
                        hit_next       = 1'b1;
                        cap_start_next = win_rd_data.start;
                        cap_size_next  = win_rd_data.size;
                        cap_tag_next   = win_rd_data.tag;
                    end
                end
                CMD_READ_DEV:
                begin
                    hit_next       = idx_ok;
                    cap_start_next = win_rd_data.start;
                    cap_size_next  = win_rd_data.size;
                    cap_tag_next   = win_rd_data.tag;
                end
                default:
                begin
                    hit_next = hit_reg;
                end
            endcase
        end

        if (handover)
        begin
            area_total_next   = area_total_reg + ACW'(area_inc);
            window_total_next = window_total_reg + WCW'(win_inc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            k_reg            <= '0;
            limit_reg        <= '0;
            rd_v_reg         <= 1'b0;
            flag_a_reg       <= 1'b0;
            flag_w_reg       <= 1'b0;
            hit_reg          <= 1'b0;
            skip_reg         <= 1'b0;
            area_total_reg   <= '0;
            window_total_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            k_reg            <= k_next;
            limit_reg        <= limit_next;
            rd_v_reg         <= rd_v_next;
            flag_a_reg       <= flag_a_next;
            flag_w_reg       <= flag_w_next;
            hit_reg          <= hit_next;
            skip_reg         <= skip_next;
            area_total_reg   <= area_total_next;
            window_total_reg <= window_total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        end_reg        <= end_next;
        rd_k_reg       <= rd_k_next;
        pre_status_reg <= pre_status_next;
        cap_start_reg  <= cap_start_next;
        cap_size_reg   <= cap_size_next;
        cap_host_reg   <= cap_host_next;
        cap_tag_reg    <= cap_tag_next;
    end

    a_area_cap: assert property (@(posedge clk) disable iff (!rst_n)
        area_total_reg <= ACW'(AREA_ENTRIES))
        else $error("area count above table depth");

    a_win_cap: assert property (@(posedge clk) disable iff (!rst_n)
        window_total_reg <= WCW'(WINDOW_ENTRIES))
        else $error("window count above table depth");

    a_counts_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(res_valid && res_ready) |=> $stable(area_total_reg) && $stable(window_total_reg))
        else $error("table count moved without a result transfer");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (k_reg < limit_reg))
        else $error("scan index past scan limit");

endmodule
